// ===== src/thresholded_edit_distance_core_assert.svh =====
// Assertion macros used by the port checker file.
`ifndef THRESHOLDED_EDIT_DISTANCE_CORE_ASSERT_SVH
`define THRESHOLDED_EDIT_DISTANCE_CORE_ASSERT_SVH

// Same-cycle implication, off during reset.
`define TEDC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define TEDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, checked through reset as well.
`define TEDC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tedc_pkg.sv =====
// Shared types and constants for the thresholded edit distance core.
package tedc_pkg;

    localparam int MAX_LEN_DEFAULT = 64;
    localparam int QUEUE_DEPTH     = 2;
    localparam int CHAR_W          = 8;
    localparam int CMD_W           = 2;
    localparam int LIMIT_W         = 7;
    localparam int DIST_W          = 7;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1);

    localparam logic [CMD_W-1:0] CMD_APPEND_FIRST  = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_APPEND_SECOND = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_COMPARE       = CMD_W'(2);

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [CHAR_W-1:0] char_code;
    } t_request;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              over_limit;
        logic              truncated;
    } t_result;

    typedef enum logic [1:0] {
        OP_APPEND_FIRST,
        OP_APPEND_SECOND,
        OP_COMPARE
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [CHAR_W-1:0] char_code;
    } t_task;

endpackage

// ===== src/tedc_ram.sv =====
// Generic simple dual-port RAM with registered read.
module tedc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/tedc_front.sv =====
// Request intake: decodes commands and queues them for the engine.
module tedc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  tedc_pkg::t_request i_request,
    output logic               o_task_valid,
    output tedc_pkg::t_task    o_task,
    input  logic               i_task_pop
);
    import tedc_pkg::*;

    localparam int QPW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    t_task            r_slot [QUEUE_DEPTH];
    logic [QPW-1:0]   r_wr_ptr;
    logic [QPW-1:0]   r_rd_ptr;
    logic [QCW-1:0]   r_count;

    logic             accept;
    logic             push;
    t_task            new_task;

    assign o_busy       = (r_count == QCW'(QUEUE_DEPTH));
    assign accept       = i_start && !o_busy;
    assign o_task_valid = (r_count != '0);
    assign o_task       = r_slot[r_rd_ptr];

    always_comb begin
        push               = 1'b0;
        new_task.op        = OP_COMPARE;
        new_task.char_code = i_request.char_code;
        unique case (i_request.command)
            CMD_APPEND_FIRST: begin
                push        = accept;
                new_task.op = OP_APPEND_FIRST;
            end
            CMD_APPEND_SECOND: begin
                push        = accept;
                new_task.op = OP_APPEND_SECOND;
            end
            CMD_COMPARE: begin
                push        = accept;
                new_task.op = OP_COMPARE;
            end
            default: begin
                push = 1'b0;  // unused code, dropped
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_slot[r_wr_ptr] <= new_task;
                r_wr_ptr         <= r_wr_ptr + QPW'(1);
            end
            if (i_task_pop) begin
                r_rd_ptr <= r_rd_ptr + QPW'(1);
            end
            if (push && !i_task_pop) begin
                r_count <= r_count + QCW'(1);
            end else if (!push && i_task_pop) begin
                r_count <= r_count - QCW'(1);
            end
        end
    end

endmodule

// ===== src/tedc_engine.sv =====
// Back end: string storage, DP sweep over one row memory, limit check.
module tedc_engine #(
    parameter int MAX_LEN = tedc_pkg::MAX_LEN_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_task_valid,
    input  tedc_pkg::t_task              i_task,
    output logic                         o_task_pop,
    input  logic                         i_cfg_valid,
    input  logic [tedc_pkg::LIMIT_W-1:0] i_cfg_data,
    output logic                         o_done,
    output tedc_pkg::t_result            o_result
);
    import tedc_pkg::*;

    localparam int AW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int DW = $clog2(MAX_LEN + 2);
    localparam int CW = (DW > LIMIT_W) ? DW : LIMIT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW_A,
        S_RUN,
        S_DRAIN,
        S_REPORT
    } t_state;

    t_state               r_state;
    logic [LIMIT_W-1:0]   r_limit;
    logic [LW-1:0]        r_len_a;
    logic [LW-1:0]        r_len_b;
    logic                 r_ovf;
    logic [LW-1:0]        r_i;
    logic [LW-1:0]        r_j;
    logic                 r_cv;
    logic [LW-1:0]        r_ci;
    logic [LW-1:0]        r_cj;
    logic [DW-1:0]        r_left;
    logic [DW-1:0]        r_diag;
    logic [DW-1:0]        r_dist;
    logic                 r_force_over;
    logic                 r_done;
    t_result              r_result;

    logic                 pop;
    logic                 full_a;
    logic                 full_b;
    logic                 a_wr_en;
    logic                 b_wr_en;
    logic [AW-1:0]        a_rd_addr;
    logic [AW-1:0]        run_addr;
    logic [AW-1:0]        row_wr_addr;
    logic [CHAR_W-1:0]    a_rd_data;
    logic [CHAR_W-1:0]    b_rd_data;
    logic [DW-1:0]        row_rd_data;
    logic [LW-1:0]        len_diff;
    logic                 report_over;

    logic [DW-1:0]        c_left;
    logic [DW-1:0]        c_diag;
    logic [DW-1:0]        c_up;
    logic [DW-1:0]        c_sub;
    logic [DW-1:0]        c_ins;
    logic [DW-1:0]        c_del;
    logic [DW-1:0]        c_min;
    logic [DW-1:0]        c_cur;

    assign pop        = (r_state == S_IDLE) && i_task_valid;
    assign o_task_pop = pop;

    assign full_a  = (r_len_a == LW'(MAX_LEN));
    assign full_b  = (r_len_b == LW'(MAX_LEN));
    assign a_wr_en = pop && (i_task.op == OP_APPEND_FIRST) && !full_a;
    assign b_wr_en = pop && (i_task.op == OP_APPEND_SECOND) && !full_b;

    assign a_rd_addr   = AW'(r_i - LW'(1));
    assign run_addr    = AW'(r_j - LW'(1));
    assign row_wr_addr = AW'(r_cj - LW'(1));

    assign len_diff = (r_len_a > r_len_b) ? (r_len_a - r_len_b) : (r_len_b - r_len_a);

    // One DP cell: row memory holds the previous row, column 0 is implicit.
    always_comb begin
        c_left = (r_cj == LW'(1)) ? DW'(r_ci) : r_left;
        c_diag = (r_cj == LW'(1)) ? DW'(r_ci - LW'(1)) : r_diag;
        c_up   = (r_ci == LW'(1)) ? DW'(r_cj) : row_rd_data;
        c_sub  = c_diag + DW'(a_rd_data != b_rd_data);
        c_ins  = c_up + DW'(1);
        c_del  = c_left + DW'(1);
        c_min  = (c_ins < c_del) ? c_ins : c_del;
        c_cur  = (c_sub < c_min) ? c_sub : c_min;
    end

    assign report_over = r_force_over || (CW'(r_dist) > CW'(r_limit));

    tedc_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_LEN)
    ) u_chars_a (
        .i_clk     (i_clk),
        .i_wr_en   (a_wr_en),
        .i_wr_addr (r_len_a[AW-1:0]),
        .i_wr_data (i_task.char_code),
        .i_rd_en   (r_state == S_ROW_A),
        .i_rd_addr (a_rd_addr),
        .o_rd_data (a_rd_data)
    );

    tedc_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_LEN)
    ) u_chars_b (
        .i_clk     (i_clk),
        .i_wr_en   (b_wr_en),
        .i_wr_addr (r_len_b[AW-1:0]),
        .i_wr_data (i_task.char_code),
        .i_rd_en   (r_state == S_RUN),
        .i_rd_addr (run_addr),
        .o_rd_data (b_rd_data)
    );

    tedc_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_LEN)
    ) u_row (
        .i_clk     (i_clk),
        .i_wr_en   (r_cv),
        .i_wr_addr (row_wr_addr),
        .i_wr_data (c_cur),
        .i_rd_en   (r_state == S_RUN),
        .i_rd_addr (run_addr),
        .o_rd_data (row_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_limit <= LIMIT_RESET;
            r_len_a <= '0;
            r_len_b <= '0;
            r_ovf   <= 1'b0;
            r_cv    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_cv   <= (r_state == S_RUN);
            r_ci   <= r_i;
            r_cj   <= r_j;

            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end

            if (r_cv) begin
                r_left <= c_cur;
                r_diag <= c_up;
                if ((r_ci == r_len_a) && (r_cj == r_len_b)) begin
                    r_dist <= c_cur;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (pop) begin
                        unique case (i_task.op)
                            OP_APPEND_FIRST: begin
                                if (full_a) begin
                                    r_ovf <= 1'b1;
                                end else begin
                                    r_len_a <= r_len_a + LW'(1);
                                end
                            end
                            OP_APPEND_SECOND: begin
                                if (full_b) begin
                                    r_ovf <= 1'b1;
                                end else begin
                                    r_len_b <= r_len_b + LW'(1);
                                end
                            end
                            OP_COMPARE: begin
                                r_force_over <= 1'b0;
                                r_i          <= LW'(1);
                                priority if ((r_len_a == '0) || (r_len_b == '0)) begin
                                    r_dist  <= DW'(r_len_a) + DW'(r_len_b);
                                    r_state <= S_REPORT;
                                end else if (CW'(len_diff) > CW'(r_limit)) begin
                                    r_force_over <= 1'b1;
                                    r_state      <= S_REPORT;
                                end else begin
                                    r_state <= S_ROW_A;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_ROW_A: begin
                    r_j     <= LW'(1);
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (r_j == r_len_b) begin
                        if (r_i == r_len_a) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_i     <= r_i + LW'(1);
                            r_state <= S_ROW_A;
                        end
                    end else begin
                        r_j <= r_j + LW'(1);
                    end
                end
                S_DRAIN: begin
                    r_state <= S_REPORT;
                end
                S_REPORT: begin
                    r_done              <= 1'b1;
                    r_result.over_limit <= report_over;
                    r_result.distance   <= report_over ? '0 : DIST_W'(r_dist);
                    r_result.truncated  <= r_ovf;
                    r_len_a             <= '0;
                    r_len_b             <= '0;
                    r_ovf               <= 1'b0;
                    r_state             <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ===== src/thresholded_edit_distance_core.sv =====
// Top level of the thresholded edit distance core.
//
// Characters load one per cycle while busy is low, through a two-entry
// request queue; busy is high only while that queue is full. Once a compare
// leaves the queue, the engine computes one DP cell per cycle over a single
// row memory, with a row-start step before each row; it skips the sweep
// when a string is empty or the length difference is over the limit.
// Each result is shown for one cycle with o_done high and cannot be held
// off by the receiver. The limit register may be written only while no
// request is outstanding.
module thresholded_edit_distance_core #(
    parameter int MAX_LEN = tedc_pkg::MAX_LEN_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  tedc_pkg::t_request           i_request,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [tedc_pkg::LIMIT_W-1:0] i_cfg_data,
    output logic                         o_done,
    output tedc_pkg::t_result            o_result
);
    import tedc_pkg::*;

    logic  task_valid;
    logic  task_pop;
    t_task task_data;

    assign o_cfg_ready = 1'b1;

    tedc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .o_busy       (busy),
        .i_request    (i_request),
        .o_task_valid (task_valid),
        .o_task       (task_data),
        .i_task_pop   (task_pop)
    );

    tedc_engine #(
        .MAX_LEN (MAX_LEN)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_task_valid (task_valid),
        .i_task       (task_data),
        .o_task_pop   (task_pop),
        .i_cfg_valid  (i_cfg_valid && o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_done       (o_done),
        .o_result     (o_result)
    );

endmodule

// ===== src/tedc_port_checker.sv =====
// Port-level checker for the thresholded edit distance core, with its bind.
`include "thresholded_edit_distance_core_assert.svh"

module tedc_port_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input tedc_pkg::t_request           i_request,
    input logic                         i_cfg_valid,
    input logic                         o_cfg_ready,
    input logic [tedc_pkg::LIMIT_W-1:0] i_cfg_data,
    input logic                         o_done,
    input tedc_pkg::t_result            o_result
);
    import tedc_pkg::*;

    logic [LIMIT_W-1:0] r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_limit <= i_cfg_data;
        end
    end

    `TEDC_ASSERT_IMPLIES(a_over_zero, i_clk, i_rst_n, o_done && o_result.over_limit, o_result.distance == '0, "over-limit result carries a nonzero distance")
    `TEDC_ASSERT_IMPLIES(a_within_limit, i_clk, i_rst_n, o_done && !o_result.over_limit, o_result.distance <= r_limit, "reported distance above the limit")
    `TEDC_ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_done, !o_done, "result strobe held for two cycles")
    `TEDC_ASSERT_NEXT_ALWAYS(a_quiet_after_reset, i_clk, !i_rst_n, !o_done, "result strobe right after reset")

endmodule

bind thresholded_edit_distance_core tedc_port_checker u_port_checker (.*);
